[hdl/atsl_pkg.sv]
package atsl_pkg;

  // Configuration register indexes on the write port.
  localparam logic [2:0] REG_MAX_SEG_LEN      = 3'd0;
  localparam logic [2:0] REG_MIN_SEG_LEN      = 3'd1;
  localparam logic [2:0] REG_LEN_STEP         = 3'd2;
  localparam logic [2:0] REG_CAP_ABORT_THRESH = 3'd3;
  localparam logic [2:0] REG_ABORT_THRESH     = 3'd4;
  localparam logic [2:0] REG_SUCCESS_THRESH   = 3'd5;

  // Event command codes as they arrive on the cmd field.
  localparam logic [1:0] CMD_OP_START  = 2'd0;
  localparam logic [1:0] CMD_SEG_START = 2'd1;
  localparam logic [1:0] CMD_ABORT     = 2'd2;
  localparam logic [1:0] CMD_FINISH    = 2'd3;

  localparam logic [7:0] CNT_SAT = 8'hFF;

  typedef enum logic [1:0] {
    EV_OP_START  = 2'd0,
    EV_SEG_START = 2'd1,
    EV_ABORT     = 2'd2,
    EV_FINISH    = 2'd3
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t kind;
    logic     cap;
  } ev_t;

  typedef struct packed {
    logic [15:0] max_len;
    logic [15:0] min_len;
    logic [7:0]  step;
    logic [7:0]  cap_thr;
    logic [7:0]  abort_thr;
    logic [15:0] succ_thr;
  } cfg_t;

  // Table entry: valid, limit, commits, commits at last capacity abort or raise.
  typedef struct packed {
    logic        valid;
    logic [15:0] limit;
    logic [31:0] succ;
    logic [31:0] saved;
  } entry_t;

endpackage

[hdl/atsl_front.sv]
module atsl_front #(
  parameter int NUM_OPS  = 16,
  parameter int NUM_SEGS = 16,
  parameter int OP_W     = 4,
  parameter int IDX_W    = 8
) (
  input  logic [1:0]       cmd,
  input  logic [3:0]       op_id,
  input  logic             capacity_abort,
  output atsl_pkg::ev_t    ev,
  output logic [IDX_W-1:0] base
);

  logic [8:0]      op_ext;
  logic [OP_W-1:0] op_sat;

  always_comb begin
    unique case (cmd)
      atsl_pkg::CMD_OP_START:  ev.kind = atsl_pkg::EV_OP_START;
      atsl_pkg::CMD_SEG_START: ev.kind = atsl_pkg::EV_SEG_START;
      atsl_pkg::CMD_ABORT:     ev.kind = atsl_pkg::EV_ABORT;
      atsl_pkg::CMD_FINISH:    ev.kind = atsl_pkg::EV_FINISH;
      default:                 ev.kind = atsl_pkg::EV_SEG_START;
    endcase
    ev.cap = capacity_abort;
  end

  // Operation indexes past the table saturate at the last operation.
  assign op_ext = 9'(op_id);
  assign op_sat = (op_ext > 9'(NUM_OPS - 1)) ? OP_W'(NUM_OPS - 1) : OP_W'(op_ext);
  assign base   = IDX_W'(op_sat) * IDX_W'(NUM_SEGS);

endmodule

[hdl/atsl_queue.sv]
module atsl_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         valid,
  output logic         full
);

  logic [W-1:0] slot [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign dout  = slot[rptr];
  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= din;
    end
  end

endmodule

[hdl/atsl_back.sv]
module atsl_back #(
  parameter int NUM_SEGS = 16,
  parameter int DEPTH    = 256,
  parameter int SEG_W    = 4,
  parameter int IDX_W    = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  atsl_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  atsl_pkg::ev_t    q_ev,
  input  logic [IDX_W-1:0] q_base,
  output logic             q_pop,
  output logic             clearing,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [15:0]      seg_limit,
  output logic             slow_path,
  output logic [3:0]       seg_index,
  output logic             index_overflow
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_RUN   = 3'b010,
    S_FILL  = 3'b100
  } state_t;

  state_t state;

  atsl_pkg::entry_t mem [DEPTH];
  atsl_pkg::entry_t rdata;
  atsl_pkg::entry_t cache;
  logic [IDX_W-1:0] clr_addr;
  logic [IDX_W-1:0] cur_idx;
  logic [SEG_W-1:0] cur_seg;
  logic [7:0]       cap_since;
  logic [7:0]       abort_cnt;
  logic             slow;

  atsl_pkg::entry_t e_touch;
  atsl_pkg::entry_t e_new;
  logic [IDX_W-1:0] idx_next;
  logic [SEG_W-1:0] seg_next;
  logic [7:0]       cap_since_next;
  logic [7:0]       abort_cnt_next;
  logic             slow_next;
  logic             ovf_next;
  logic             wr_cur;
  logic             fetch;
  logic             out_free;
  logic             res_load;
  logic [15:0]      lim_dec;
  logic [16:0]      lim_sum;
  logic [15:0]      lim_inc;
  logic [31:0]      succ_inc;
  logic [31:0]      succ_diff;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  atsl_pkg::entry_t mem_wdata;

  assign clearing = (state == S_CLEAR);
  assign out_free = !res_valid || !res_stall;
  assign q_pop    = (state == S_RUN) && q_valid && out_free;

  // The current entry lives in the cache; an entry never written starts from the maximum.
  always_comb begin
    e_touch = cache;
    if (!cache.valid) begin
      e_touch.valid = 1'b1;
      e_touch.limit = cfg.max_len;
      e_touch.succ  = '0;
      e_touch.saved = '0;
    end
  end

  assign lim_dec   = (e_touch.limit > cfg.min_len) ?
                     ((e_touch.limit > 16'(cfg.step)) ? e_touch.limit - 16'(cfg.step) : 16'd0) :
                     e_touch.limit;
  assign lim_sum   = 17'(e_touch.limit) + 17'(cfg.step);
  assign lim_inc   = (lim_sum > 17'(cfg.max_len)) ? cfg.max_len : lim_sum[15:0];
  assign succ_inc  = e_touch.succ + 32'd1;
  assign succ_diff = succ_inc - e_touch.saved;

  always_comb begin
    e_new          = cache;
    idx_next       = cur_idx;
    seg_next       = cur_seg;
    cap_since_next = cap_since;
    abort_cnt_next = abort_cnt;
    slow_next      = slow;
    ovf_next       = 1'b0;
    wr_cur         = 1'b0;
    unique case (q_ev.kind)
      atsl_pkg::EV_OP_START: begin
        slow_next      = 1'b0;
        seg_next       = '0;
        idx_next       = q_base;
        cap_since_next = '0;
        abort_cnt_next = '0;
      end
      atsl_pkg::EV_SEG_START: begin
        cap_since_next = '0;
        abort_cnt_next = '0;
      end
      atsl_pkg::EV_ABORT: begin
        if (!slow) begin
          e_new  = e_touch;
          wr_cur = 1'b1;
          if (abort_cnt != atsl_pkg::CNT_SAT) begin
            abort_cnt_next = abort_cnt + 8'd1;
          end
          if (q_ev.cap && cap_since != atsl_pkg::CNT_SAT) begin
            cap_since_next = cap_since + 8'd1;
          end
          if (cap_since_next != 8'd0) begin
            e_new.saved = e_touch.succ;
          end
          if (cap_since_next > cfg.cap_thr) begin
            e_new.limit    = lim_dec;
            cap_since_next = '0;
          end
          if (abort_cnt_next > cfg.abort_thr) begin
            slow_next = 1'b1;
          end
        end
      end
      atsl_pkg::EV_FINISH: begin
        if (slow) begin
          slow_next = 1'b0;
        end else begin
          e_new      = e_touch;
          wr_cur     = 1'b1;
          e_new.succ = succ_inc;
          if (succ_diff > 32'(cfg.succ_thr) && e_touch.limit < cfg.max_len) begin
            e_new.limit = lim_inc;
            e_new.saved = succ_inc;
          end
        end
        if (cur_seg == SEG_W'(NUM_SEGS - 1)) begin
          ovf_next = 1'b1;
        end else begin
          seg_next = cur_seg + SEG_W'(1);
          idx_next = cur_idx + IDX_W'(1);
        end
      end
      default: begin
        e_new = cache;
      end
    endcase
  end

  // A move to another entry needs that entry read from the table first.
  assign fetch = (idx_next != cur_idx);

  assign res_load = (q_pop && !fetch) || ((state == S_FILL) && out_free);

  assign mem_we    = clearing || (q_pop && wr_cur);
  assign mem_waddr = clearing ? clr_addr : cur_idx;
  assign mem_wdata = clearing ? '0 : e_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop && fetch) begin
      rdata <= mem[idx_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      cache.valid <= 1'b0;
      cur_idx     <= '0;
      cur_seg     <= '0;
      cap_since   <= '0;
      abort_cnt   <= '0;
      slow        <= 1'b1;
      res_valid   <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(DEPTH - 1)) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (q_pop) begin
            cache     <= e_new;
            cur_idx   <= idx_next;
            cur_seg   <= seg_next;
            cap_since <= cap_since_next;
            abort_cnt <= abort_cnt_next;
            slow      <= slow_next;
            if (fetch) begin
              state <= S_FILL;
            end else begin
              seg_limit      <= e_new.valid ? e_new.limit : cfg.max_len;
              slow_path      <= slow_next;
              seg_index      <= 4'(seg_next);
              index_overflow <= ovf_next;
            end
          end
        end
        S_FILL: begin
          if (out_free) begin
            cache          <= rdata;
            seg_limit      <= rdata.valid ? rdata.limit : cfg.max_len;
            slow_path      <= slow;
            seg_index      <= 4'(cur_seg);
            index_overflow <= 1'b0;
            state          <= S_RUN;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

[hdl/adaptive_tx_segment_limit.sv]
// Adaptive segment length limiter for transactional execution.
// Events come in on the ev channel (cmd, op_id, capacity_abort) and each one
// produces exactly one result on the res channel (seg_limit, slow_path,
// seg_index, index_overflow). A transfer happens when valid is high and
// stall is low. Configuration registers are written through wr_en, wr_index
// and wr_data; the user must write only with no event in flight (not enforced).
// Accepted events enter a two-entry queue; while res_stall is low the back end
// then handles one event per cycle when it stays on the same table entry; when
// the event moves to another entry it passes through S_FILL, since that entry
// comes from the table through its registered read port. The result register
// is loaded as the event leaves the queue, or from S_FILL once it is fetched.
// After reset the table is cleared one entry per cycle, all NUM_OPS * NUM_SEGS
// entries; ev_stall stays high during that pass. Configuration writes
// are taken during the pass too.
// The result sits in an output register. While res_stall is high a valid result
// holds, the back end stops, and the queue keeps taking events until it is full.
module adaptive_tx_segment_limit #(
  parameter int NUM_OPS  = 16,
  parameter int NUM_SEGS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        ev_valid,
  output logic        ev_stall,
  input  logic [1:0]  cmd,
  input  logic [3:0]  op_id,
  input  logic        capacity_abort,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] seg_limit,
  output logic        slow_path,
  output logic [3:0]  seg_index,
  output logic        index_overflow
);

  localparam int DEPTH  = NUM_OPS * NUM_SEGS;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OP_W   = (NUM_OPS > 1) ? $clog2(NUM_OPS) : 1;
  localparam int SEG_W  = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
  localparam int QW     = $bits(atsl_pkg::ev_t) + IDX_W;
  localparam logic [3:0] LAST_SEG4 = 4'((NUM_SEGS - 1) % 16);

  atsl_pkg::cfg_t   cfg;
  atsl_pkg::ev_t    f_ev;
  logic [IDX_W-1:0] f_base;
  atsl_pkg::ev_t    q_ev;
  logic [IDX_W-1:0] q_base;
  logic [QW-1:0]    q_dout;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  logic             q_full;
  logic             clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_len   <= 16'd64;
      cfg.min_len   <= 16'd4;
      cfg.step      <= 8'd1;
      cfg.cap_thr   <= 8'd2;
      cfg.abort_thr <= 8'd10;
      cfg.succ_thr  <= 16'd10;
    end else if (wr_en) begin
      unique case (wr_index)
        atsl_pkg::REG_MAX_SEG_LEN:      cfg.max_len   <= wr_data;
        atsl_pkg::REG_MIN_SEG_LEN:      cfg.min_len   <= wr_data;
        atsl_pkg::REG_LEN_STEP:         cfg.step      <= wr_data[7:0];
        atsl_pkg::REG_CAP_ABORT_THRESH: cfg.cap_thr   <= wr_data[7:0];
        atsl_pkg::REG_ABORT_THRESH:     cfg.abort_thr <= wr_data[7:0];
        atsl_pkg::REG_SUCCESS_THRESH:   cfg.succ_thr  <= wr_data;
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  assign ev_stall = q_full || clearing;
  assign q_push   = ev_valid && !ev_stall;

  atsl_front #(
    .NUM_OPS  (NUM_OPS),
    .NUM_SEGS (NUM_SEGS),
    .OP_W     (OP_W),
    .IDX_W    (IDX_W)
  ) u_front (
    .cmd            (cmd),
    .op_id          (op_id),
    .capacity_abort (capacity_abort),
    .ev             (f_ev),
    .base           (f_base)
  );

  atsl_queue #(
    .W (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({f_ev, f_base}),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid),
    .full  (q_full)
  );

  assign q_ev   = atsl_pkg::ev_t'(q_dout[QW-1:IDX_W]);
  assign q_base = q_dout[IDX_W-1:0];

  atsl_back #(
    .NUM_SEGS (NUM_SEGS),
    .DEPTH    (DEPTH),
    .SEG_W    (SEG_W),
    .IDX_W    (IDX_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_valid        (q_valid),
    .q_ev           (q_ev),
    .q_base         (q_base),
    .q_pop          (q_pop),
    .clearing       (clearing),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .seg_limit      (seg_limit),
    .slow_path      (slow_path),
    .seg_index      (seg_index),
    .index_overflow (index_overflow)
  );

  // A held segment index is always the last segment.
  a_ovf_last_seg: assert property (@(posedge clk) disable iff (rst)
    res_valid && index_overflow |-> seg_index == LAST_SEG4)
    else $error("index_overflow with a segment other than the last");

  // Overflow only comes from a segment finish, which always leaves the slow path.
  a_ovf_not_slow: assert property (@(posedge clk) disable iff (rst)
    res_valid && index_overflow |-> !slow_path)
    else $error("segment finish result still on the slow path");

  // No event is processed while the table is being cleared.
  a_no_result_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !res_valid && !q_pop)
    else $error("result produced during table clearing");

  // The queue never drains on a cycle with a stalled, waiting result.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> !q_pop)
    else $error("event taken from queue while a result is stalled");

endmodule

[bench/seg_limit_check.sv]
module seg_limit_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  input  logic        ev_valid,
  input  logic        ev_stall,
  input  logic [1:0]  cmd,
  input  logic [3:0]  op_id,
  input  logic        capacity_abort,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [15:0] seg_limit,
  input  logic        slow_path,
  input  logic [3:0]  seg_index,
  input  logic        index_overflow,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [15:0] lim;
    logic        slow;
    logic [3:0]  seg;
    logic        ovf;
  } seg_result_t;

  atsl_pkg::cfg_t   cfg;
  atsl_pkg::entry_t tbl [256];
  logic [3:0]       cur_op;
  logic [3:0]       cur_seg;
  logic [7:0]       cap_run;
  logic [7:0]       abort_run;
  logic             slow;
  seg_result_t      due_results [$];

  function automatic void clear_tracker();
    cfg = '{max_len: 16'd64, min_len: 16'd4, step: 8'd1, cap_thr: 8'd2,
            abort_thr: 8'd10, succ_thr: 16'd10};
    foreach (tbl[i]) tbl[i].valid = 1'b0;
    cur_op = '0;
    cur_seg = '0;
    cap_run = '0;
    abort_run = '0;
    slow = 1'b1;
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [15:0] data);
    case (idx)
      atsl_pkg::REG_MAX_SEG_LEN:      cfg.max_len = data;
      atsl_pkg::REG_MIN_SEG_LEN:      cfg.min_len = data;
      atsl_pkg::REG_LEN_STEP:         cfg.step = data[7:0];
      atsl_pkg::REG_CAP_ABORT_THRESH: cfg.cap_thr = data[7:0];
      atsl_pkg::REG_ABORT_THRESH:     cfg.abort_thr = data[7:0];
      atsl_pkg::REG_SUCCESS_THRESH:   cfg.succ_thr = data;
      default: ;
    endcase
  endfunction

  // An entry that was never written starts at the current maximum with zero counts.
  function automatic void open_entry(logic [7:0] ix);
    if (!tbl[ix].valid) begin
      tbl[ix].valid = 1'b1;
      tbl[ix].limit = cfg.max_len;
      tbl[ix].succ = '0;
      tbl[ix].saved = '0;
    end
  endfunction

  function automatic seg_result_t step_limit_table(logic [1:0] c, logic [3:0] op, logic cap);
    logic [7:0]  ix;
    int unsigned lim;
    seg_result_t r;
    r.ovf = 1'b0;
    case (c)
      atsl_pkg::CMD_OP_START: begin
        cur_op = op;
        cur_seg = '0;
        slow = 1'b0;
        cap_run = '0;
        abort_run = '0;
      end
      atsl_pkg::CMD_SEG_START: begin
        cap_run = '0;
        abort_run = '0;
      end
      atsl_pkg::CMD_ABORT: begin
        if (!slow) begin
          ix = {cur_op, cur_seg};
          open_entry(ix);
          if (abort_run != atsl_pkg::CNT_SAT) abort_run++;
          if (cap && cap_run != atsl_pkg::CNT_SAT) cap_run++;
          if (cap_run != 0) tbl[ix].saved = tbl[ix].succ;
          if (cap_run > cfg.cap_thr) begin
            lim = tbl[ix].limit;
            if (lim > cfg.min_len) lim = (lim > cfg.step) ? lim - cfg.step : 0;
            tbl[ix].limit = lim[15:0];
            cap_run = '0;
          end
          if (abort_run > cfg.abort_thr) slow = 1'b1;
        end
      end
      default: begin
        if (slow) begin
          slow = 1'b0;
        end else begin
          ix = {cur_op, cur_seg};
          open_entry(ix);
          tbl[ix].succ = tbl[ix].succ + 32'd1;
          lim = tbl[ix].limit;
          if (32'(tbl[ix].succ - tbl[ix].saved) > cfg.succ_thr && lim < cfg.max_len) begin
            lim = lim + cfg.step;
            if (lim > cfg.max_len) lim = cfg.max_len;
            tbl[ix].limit = lim[15:0];
            tbl[ix].saved = tbl[ix].succ;
          end
        end
        if (cur_seg != 4'd15) cur_seg++;
        else r.ovf = 1'b1;
      end
    endcase
    ix = {cur_op, cur_seg};
    r.lim = tbl[ix].valid ? tbl[ix].limit : cfg.max_len;
    r.slow = slow;
    r.seg = cur_seg;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    seg_result_t want;
    if (rst) begin
      clear_tracker();
      due_results.delete();
    end else begin
      if (wr_en) write_reg(wr_index, wr_data);
      if (ev_valid && !ev_stall)
        due_results.push_back(step_limit_table(cmd, op_id, capacity_abort));
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no event waiting: seg_limit %0d seg_index %0d",
                   $time, seg_limit, seg_index);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("seg_limit", want.lim, seg_limit);
          check_field("slow_path", 16'(want.slow), 16'(slow_path));
          check_field("seg_index", 16'(want.seg), 16'(seg_index));
          check_field("index_overflow", 16'(want.ovf), 16'(index_overflow));
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

[bench/testbench.sv]
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [15:0] wr_data = '0;
  logic        ev_valid = 1'b0;
  logic        ev_stall;
  logic [1:0]  cmd = atsl_pkg::CMD_OP_START;
  logic [3:0]  op_id = '0;
  logic        capacity_abort = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [15:0] seg_limit;
  logic        slow_path;
  logic [3:0]  seg_index;
  logic        index_overflow;
  int          mismatches;
  int          pending;

  int gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int items_sent = 0;

  adaptive_tx_segment_limit uut (.*);

  seg_limit_check limit_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off when the top asks for it.
  always @(posedge clk) begin
    int hold_ack;
    int hold_left;
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = 300;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_event(input logic [1:0] c, input logic [3:0] op, input logic cap);
    if ($urandom_range(99) < gap_pct) begin
      ev_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    ev_valid <= 1'b1;
    cmd <= c;
    op_id <= op;
    capacity_abort <= cap;
    do @(posedge clk); while (ev_stall);
    items_sent++;
  endtask

  task automatic configure(input logic [15:0] max_len, input logic [15:0] min_len,
                           input logic [15:0] step, input logic [15:0] cap_thr,
                           input logic [15:0] abort_thr, input logic [15:0] succ_thr);
    logic [15:0] vals [6];
    vals = '{max_len, min_len, step, cap_thr, abort_thr, succ_thr};
    wr_en <= 1'b1;
    foreach (vals[i]) begin
      wr_index <= 3'(i);
      wr_data <= vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int gap, input int stall);
    gap_pct <= gap;
    stall_pct <= stall;
  endtask

  // Wait until every transfer has produced its result.
  task automatic drain();
    ev_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Well-formed operations with random content, sprinkled with stray events.
  task automatic run_sequences(input int n, input int abort_max);
    int stop_at;
    int segs;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(7) == 0)
        send_event(2'($urandom_range(3)), 4'($urandom_range(15)), 1'($urandom_range(1)));
      send_event(atsl_pkg::CMD_OP_START,
                 4'(($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1)),
                 1'($urandom_range(1)));
      segs = ($urandom_range(4) == 0) ? $urandom_range(20, 5) : $urandom_range(4, 1);
      repeat (segs) begin
        if ($urandom_range(7) == 0)
          send_event(atsl_pkg::CMD_SEG_START, 4'($urandom_range(15)), 1'($urandom_range(1)));
        repeat ($urandom_range(abort_max))
          send_event(atsl_pkg::CMD_ABORT, 4'($urandom_range(15)), ($urandom_range(2) != 0));
        send_event(atsl_pkg::CMD_FINISH, 4'($urandom_range(15)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset values, then a short walk through the special cases.
    configure(16'd64, 16'd4, 16'd1, 16'd2, 16'd10, 16'd10);
    send_event(atsl_pkg::CMD_ABORT, 4'h0, 1'b1);
    send_event(atsl_pkg::CMD_FINISH, 4'hF, 1'b0);
    send_event(atsl_pkg::CMD_ABORT, 4'h0, 1'b0);
    send_event(atsl_pkg::CMD_OP_START, 4'hF, 1'b0);
    repeat (3) send_event(atsl_pkg::CMD_ABORT, 4'hA, 1'b1);
    send_event(atsl_pkg::CMD_SEG_START, 4'h5, 1'b1);
    repeat (16) send_event(atsl_pkg::CMD_FINISH, 4'h0, 1'b0);
    run_sequences(200, 4);
    drain();

    configure(16'hFFFF, 16'd0, 16'd255, 16'd0, 16'd0, 16'd0);
    set_idling(82, 0);
    run_sequences(200, 3);
    drain();

    configure(16'd5, 16'd0, 16'd3, 16'd1, 16'd3, 16'd2);
    set_idling(0, 82);
    run_sequences(200, 5);
    drain();

    configure(16'd300, 16'd250, 16'd255, 16'd0, 16'd4, 16'd1);
    set_idling(19, 19);
    run_sequences(200, 6);
    drain();

    // Counters pinned at their ceiling, with the result side held off so the
    // event queue fills and backs up the sender.
    configure(16'd300, 16'd10, 16'd7, 16'hFF, 16'hFF, 16'hFFFF);
    set_idling(0, 0);
    hold_req <= hold_req + 1;
    send_event(atsl_pkg::CMD_OP_START, 4'h3, 1'b0);
    repeat (300) send_event(atsl_pkg::CMD_ABORT, 4'h3, 1'($urandom_range(1)));
    send_event(atsl_pkg::CMD_FINISH, 4'h3, 1'b0);
    run_sequences(100, 3);
    drain();

    // Only the low bits of the narrow registers are kept.
    configure(16'd1, 16'hFFFF, 16'hAB01, 16'h5A03, 16'hC305, 16'd3);
    set_idling(82, 82);
    run_sequences(200, 8);
    drain();

    configure(16'($urandom_range(65535, 1)), 16'($urandom), 16'($urandom_range(65535, 1)),
              16'($urandom), 16'($urandom), 16'($urandom_range(15)));
    set_idling(0, 0);
    run_sequences(100, 12);
    set_idling(19, 19);
    run_sequences(100, 12);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule
